FILE: rtl/core/pwmicm_pkg.sv
// ----------------------------------------------------------------------------
// PWM input capture measurement package
// Shared widths, item codes and the result record of the measurement block.
// ----------------------------------------------------------------------------
package pwmicm_pkg;

   localparam int VALUE_W    = 16;
   localparam int TIME_W     = 24;
   localparam int DUTY_W     = 16;
   localparam int RSP_DATA_W = 96;

   localparam logic OP_OVERFLOW = 1'b0;
   localparam logic OP_CAPTURE  = 1'b1;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_fraction;
      logic [TIME_W-1:0] period_ticks;
      logic [TIME_W-1:0] low_ticks;
      logic [TIME_W-1:0] high_ticks;
      logic              measurement_valid;
      logic              counter_clear;
      logic              edge_polarity;
      logic              capture_enable;
   } result_type;

endpackage

FILE: rtl/core/pwm_input_capture_measure.sv
// ----------------------------------------------------------------------------
// PWM input capture measurement
// Measures high time, low time, period and duty of a PWM input.
// ----------------------------------------------------------------------------
// The req channel carries one item per transfer: req_tuser says whether it is
// a counter overflow tick or a capture edge, req_tdata holds the latched count.
// Every item gives exactly one result transfer on the rsp channel with the
// capture controls, the two strobes and the held measurements.
// An ordinary item is accepted, its result then enters the output register as
// soon as that register is free, and only then does the block take a new
// item. The overflow tick that closes a measurement runs the duty division,
// one quotient bit per cycle; the divider returns zero for a zero period and
// all ones when the period is not above the high time, without shifting.
// Reset clears the phase, the overflow count and all measurements; capture is
// disarmed and the next edge is rising. While the receiver stalls, the result
// stays in the output register, one further item is accepted and finished,
// and req_tready then stays low until the output register is taken.
// ----------------------------------------------------------------------------
module pwm_input_capture_measure #(
   parameter int COUNTER_BITS   = 16,
   parameter int OVERFLOW_BITS  = 8,
   parameter int DUTY_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] capture_value
   input  logic [0:0]  req_tuser,  // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata   // [0] capture_enable, [1] edge_polarity,
                                   // [2] counter_clear, [3] measurement_valid,
                                   // [27:4] high_ticks, [51:28] low_ticks,
                                   // [75:52] period_ticks, [91:76] duty_fraction
);

   localparam int TB = COUNTER_BITS + OVERFLOW_BITS;
   localparam int RW = pwmicm_pkg::RSP_DATA_W;

   pwmicm_pkg::result_type    result;
   logic                      res_valid;
   logic                      res_take;
   logic                      div_start;
   logic [TB-1:0]             div_num;
   logic [TB-1:0]             div_den;
   logic                      div_done;
   logic [DUTY_FRAC_BITS-1:0] div_quot;

   logic                      rsp_valid_ff, rsp_valid_in;
   pwmicm_pkg::result_type    rsp_data_ff, rsp_data_in;

   pwmicm_seq #(
      .COUNTER_BITS   (COUNTER_BITS),
      .OVERFLOW_BITS  (OVERFLOW_BITS),
      .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item_op    (req_tuser[0]),
      .item_value (req_tdata),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .result     (result),
      .div_start  (div_start),
      .div_num    (div_num),
      .div_den    (div_den),
      .div_done   (div_done),
      .div_quot   (div_quot)
   );

   pwmicm_div #(
      .TIME_BITS (TB),
      .FRAC_BITS (DUTY_FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RW'(rsp_data_ff);

endmodule

FILE: rtl/core/pwmicm_div.sv
// ----------------------------------------------------------------------------
// PWM input capture duty divider
// Restoring divider that shifts one quotient bit into a register per cycle.
// ----------------------------------------------------------------------------
module pwmicm_div #(
   parameter int TIME_BITS = 24,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] num,
   input  logic [TIME_BITS-1:0] den,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(FRAC_BITS);

   typedef enum logic {DV_IDLE, DV_RUN} div_state_type;

   div_state_type        state_ff, state_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] den_ff, den_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [TIME_BITS:0] rem_shift;
   logic [TIME_BITS:0] rem_diff;
   logic               fits;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               if (den == '0) begin
                  quot_in = '0;
                  done_in = 1'b1;
               end else if (num >= den) begin
                  quot_in = '1;
                  done_in = 1'b1;
               end else begin
                  rem_in   = num;
                  den_in   = den;
                  quot_in  = '0;
                  cnt_in   = CNT_W'(FRAC_BITS - 1);
                  state_in = DV_RUN;
               end
            end
         end
         DV_RUN: begin
            rem_in  = fits ? rem_diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], fits};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = DV_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/core/pwmicm_seq.sv
// ----------------------------------------------------------------------------
// PWM input capture sequencer
// Five-phase capture sequence, overflow counting and the measured times.
// ----------------------------------------------------------------------------
module pwmicm_seq #(
   parameter int COUNTER_BITS   = 16,
   parameter int OVERFLOW_BITS  = 8,
   parameter int DUTY_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   item_valid,
   output logic                                   item_ready,
   input  logic                                   item_op,
   input  logic [pwmicm_pkg::VALUE_W-1:0]         item_value,
   output logic                                   res_valid,
   input  logic                                   res_take,
   output pwmicm_pkg::result_type                 result,
   output logic                                   div_start,
   output logic [COUNTER_BITS+OVERFLOW_BITS-1:0]  div_num,
   output logic [COUNTER_BITS+OVERFLOW_BITS-1:0]  div_den,
   input  logic                                   div_done,
   input  logic [DUTY_FRAC_BITS-1:0]              div_quot
);

   localparam int TB = COUNTER_BITS + OVERFLOW_BITS;
   localparam int TW = pwmicm_pkg::TIME_W;
   localparam int DW = pwmicm_pkg::DUTY_W;

   typedef enum logic [2:0] {PH_IDLE, PH_ARMED, PH_HIGH, PH_LOW, PH_CLOSE} phase_type;
   typedef enum logic [1:0] {ST_READY, ST_DIV, ST_DONE} step_type;

   phase_type                 phase_ff, phase_in;
   step_type                  step_ff, step_in;
   logic [OVERFLOW_BITS-1:0]  ovf_ff, ovf_in;
   logic [COUNTER_BITS-1:0]   first_rise_ff, first_rise_in;
   logic [TB-1:0]             high_ff, high_in;
   logic [TB-1:0]             low_ff, low_in;
   logic [TB-1:0]             period_ff, period_in;
   logic [DUTY_FRAC_BITS-1:0] duty_ff, duty_in;
   logic                      pol_ff, pol_in;
   logic                      arm_ff, arm_in;
   logic                      flag_ff, flag_in;

   logic                      accept;
   logic [COUNTER_BITS-1:0]   edge_count;
   logic [TB-1:0]             span;

   assign accept     = item_valid && (step_ff == ST_READY);
   assign edge_count = COUNTER_BITS'(item_value);
   assign span       = (TB'(ovf_ff) << COUNTER_BITS) + TB'(edge_count) - TB'(first_rise_ff);

   always_comb begin
      phase_in      = phase_ff;
      step_in       = step_ff;
      ovf_in        = ovf_ff;
      first_rise_in = first_rise_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      period_in     = period_ff;
      duty_in       = duty_ff;
      pol_in        = pol_ff;
      arm_in        = arm_ff;
      flag_in       = flag_ff;
      div_start     = 1'b0;
      unique case (step_ff)
         ST_READY: begin
            if (accept) begin
               step_in = ST_DONE;
               flag_in = 1'b0;
               if (item_op == pwmicm_pkg::OP_OVERFLOW) begin
                  unique case (phase_ff)
                     PH_ARMED, PH_HIGH, PH_LOW: begin
                        if (ovf_ff != '1) begin
                           ovf_in = ovf_ff + OVERFLOW_BITS'(1);
                        end
                     end
                     PH_CLOSE: begin
                        ovf_in    = '0;
                        phase_in  = PH_IDLE;
                        flag_in   = 1'b1;
                        step_in   = ST_DIV;
                        div_start = 1'b1;
                     end
                     default: begin
                        phase_in = PH_ARMED;
                        pol_in   = 1'b0;
                        arm_in   = 1'b1;
                     end
                  endcase
               end else begin
                  unique case (phase_ff)
                     PH_ARMED: begin
                        first_rise_in = edge_count;
                        ovf_in        = '0;
                        pol_in        = 1'b1;
                        phase_in      = PH_HIGH;
                     end
                     PH_HIGH: begin
                        high_in  = span;
                        pol_in   = 1'b0;
                        phase_in = PH_LOW;
                     end
                     PH_LOW: begin
                        period_in = span;
                        low_in    = span - high_ff;
                        arm_in    = 1'b0;
                        phase_in  = PH_CLOSE;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               duty_in = div_quot;
               step_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               step_in = ST_READY;
            end
         end
         default: step_in = ST_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         step_ff       <= ST_READY;
         ovf_ff        <= '0;
         first_rise_ff <= '0;
         high_ff       <= '0;
         low_ff        <= '0;
         period_ff     <= '0;
         duty_ff       <= '0;
         pol_ff        <= 1'b0;
         arm_ff        <= 1'b0;
         flag_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         step_ff       <= step_in;
         ovf_ff        <= ovf_in;
         first_rise_ff <= first_rise_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         period_ff     <= period_in;
         duty_ff       <= duty_in;
         pol_ff        <= pol_in;
         arm_ff        <= arm_in;
         flag_ff       <= flag_in;
      end
   end

   assign item_ready = (step_ff == ST_READY);
   assign res_valid  = (step_ff == ST_DONE);
   assign div_num    = high_ff;
   assign div_den    = period_ff;

   assign result.capture_enable    = arm_ff;
   assign result.edge_polarity     = pol_ff;
   assign result.counter_clear     = flag_ff;
   assign result.measurement_valid = flag_ff;
   assign result.high_ticks        = TW'(high_ff);
   assign result.low_ticks         = TW'(low_ff);
   assign result.period_ticks      = TW'(period_ff);
   assign result.duty_fraction     = DW'(duty_ff);

endmodule

FILE: rtl/core/pwmicm_chk.sv
// ----------------------------------------------------------------------------
// PWM input capture measurement checker
// Port-level assertions on the measurement block, bound to the top level.
// ----------------------------------------------------------------------------
module pwmicm_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result channel is valid right after reset.");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result transfer changed or was dropped.");

   a_one_item : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("A second item was taken while one was still in work.");

   a_strobes : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3] == rsp_tdata[2])
      else $error("Measurement strobe and counter clear disagree.");

   a_close_disarmed : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[0] && !rsp_tdata[1])
      else $error("Measurement completed while capture is still armed.");

endmodule

bind pwm_input_capture_measure pwmicm_chk u_pwmicm_chk (.*);
